FILE: src/hamming_radius_sketch_search_macros.svh
// Assertion macros for the sketch search block.
`ifndef HAMMING_RADIUS_SKETCH_SEARCH_MACROS_SVH
`define HAMMING_RADIUS_SKETCH_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define HRSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HRSS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HRSS_ASSERT(label, clk, rst, prop, msg)
`define HRSS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: src/hrss_pkg.sv
// Shared constants and types for the sketch search block.
package hrss_pkg;
  localparam int MaxEntries = 64;
  localparam int MaxLength  = 64;
  localparam int EntW = $clog2(MaxEntries);
  localparam int PosW = $clog2(MaxLength);
  localparam int DbAw = EntW + PosW;

  localparam logic OP_DB    = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_SYMBOL_BITS   = 2'd0;
  localparam logic [1:0] REG_VECTOR_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_ERRORS    = 2'd2;
  localparam logic [1:0] REG_ENTRY_COUNT   = 2'd3;

  typedef struct packed {
    logic [7:0] mask;
    logic [6:0] len;
    logic [6:0] limit;
    logic [6:0] count;
  } hrss_cfg_t;

  function automatic logic [7:0] sym_mask(input logic [3:0] bits);
    logic [7:0] m;
    m = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (bits > 4'(i)) m[i] = 1'b1;
    end
    return m;
  endfunction
endpackage

FILE: src/hrss_scan.sv
// Distance engine: symbol stores and one shared compare/count unit.
`include "hamming_radius_sketch_search_macros.svh"
module hrss_scan import hrss_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic            wr_query,
  input  logic [EntW-1:0] wr_entry,
  input  logic [PosW-1:0] wr_pos,
  input  logic [7:0]      wr_sym,
  input  logic            start,
  input  hrss_cfg_t       cfg,
  output logic            busy,
  output logic            dist_valid,
  output logic [EntW-1:0] dist_entry,
  output logic [6:0]      dist_value,
  output logic            done
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_NEXT} state_t;

  logic [7:0] db_mem [MaxEntries*MaxLength];
  logic [7:0] q_mem  [MaxLength];
  logic [7:0] db_rd, q_rd;
  state_t     state;
  logic [EntW:0] entry;
  logic [PosW:0] pos;
  logic [6:0] errs;
  logic       mism;

  // write stores, registered reads
  always_ff @(posedge clk) begin
    if (wr_en && !wr_query) db_mem[{wr_entry, wr_pos}] <= wr_sym;
    if (wr_en && wr_query) q_mem[wr_pos] <= wr_sym;
    db_rd <= db_mem[{entry[EntW-1:0], pos[PosW-1:0]}];
    q_rd  <= q_mem[pos[PosW-1:0]];
  end

  assign mism = ((db_rd ^ q_rd) & cfg.mask) != 8'd0;

  // walk entries and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dist_valid <= 1'b0;
      done <= 1'b0;
      entry <= '0;
      pos <= '0;
      errs <= '0;
    end else begin
      dist_valid <= 1'b0;
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            entry <= '0;
            pos <= '0;
            errs <= '0;
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if ({1'b0, entry} >= {1'b0, cfg.count}) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else if ({1'b0, pos} >= {1'b0, cfg.len} || errs > cfg.limit) begin
            dist_valid <= 1'b1;
            dist_entry <= entry[EntW-1:0];
            dist_value <= errs;
            entry <= entry + (EntW+1)'(1);
            pos <= '0;
            errs <= '0;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (mism) errs <= errs + 7'd1;
          pos <= pos + (PosW+1)'(1);
          state <= S_NEXT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `HRSS_ASSERT(a_errs_bound, clk, rst, errs <= 7'(MaxLength), "error count overflow")
  `HRSS_ASSERT(a_start_idle, clk, rst, start |-> state == S_IDLE, "start while busy")
  `HRSS_ASSERT(a_done_idle, clk, rst, done |=> state == S_IDLE, "done not idle")
endmodule

FILE: src/hrss_order.sv
// Result sorter: distance table swept once per distance, output register.
`include "hamming_radius_sketch_search_macros.svh"
module hrss_order import hrss_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            dist_valid,
  input  logic [EntW-1:0] dist_entry,
  input  logic [6:0]      dist_value,
  input  logic            scan_done,
  input  hrss_cfg_t       cfg,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [EntW-1:0] match_id,
  output logic [6:0]      distance,
  output logic            last_result,
  output logic            empty_res
);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_FLUSH, S_WAIT} state_t;

  logic [6:0] dtab [MaxEntries];
  logic [6:0] rd;
  state_t state;
  logic [EntW:0] e;
  logic [6:0] d;
  logic [EntW:0] n;
  logic have;
  logic [EntW-1:0] h_id;
  logic [6:0] h_d;
  logic [6:0] lim;
  logic load;

  assign lim = (cfg.limit > 7'(MaxLength)) ? 7'(MaxLength) : cfg.limit;

  // load the output register when it is free and an item is ready
  assign load = (!out_valid || !out_stall) &&
                ((state == S_CHK && rd == d && have) || state == S_FLUSH);

  always_ff @(posedge clk) begin
    if (dist_valid) dtab[dist_entry] <= dist_value;
    rd <= dtab[e[EntW-1:0]];
  end

  // sweep distances and entries; hold one pending match to mark the last
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      have <= 1'b0;
      n <= '0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (scan_done) begin
            e <= '0;
            d <= '0;
            n <= '0;
            have <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (d > lim || n >= (EntW+1)'(MaxEntries)) state <= S_FLUSH;
          else if ({1'b0, e} >= {1'b0, cfg.count}) begin
            e <= '0;
            d <= d + 7'd1;
          end else state <= S_CHK;
        end
        S_CHK: begin
          if (rd == d) begin
            if (have) begin
              if (!out_valid || !out_stall) begin
                match_id <= h_id;
                distance <= h_d;
                last_result <= 1'b0;
                empty_res <= 1'b0;
                h_id <= e[EntW-1:0];
                h_d <= d;
                n <= n + (EntW+1)'(1);
                e <= e + (EntW+1)'(1);
                state <= S_RD;
              end
            end else begin
              have <= 1'b1;
              h_id <= e[EntW-1:0];
              h_d <= d;
              n <= n + (EntW+1)'(1);
              e <= e + (EntW+1)'(1);
              state <= S_RD;
            end
          end else begin
            e <= e + (EntW+1)'(1);
            state <= S_RD;
          end
        end
        S_FLUSH: begin
          if (!out_valid || !out_stall) begin
            last_result <= 1'b1;
            empty_res <= !have;
            match_id <= have ? h_id : '0;
            distance <= have ? h_d : 7'd0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `HRSS_ASSERT(a_cnt, clk, rst, n <= (EntW+1)'(MaxEntries), "too many results")
  `HRSS_ASSERT(a_empty, clk, rst, (out_valid && empty_res) |-> last_result, "empty not last")
  `HRSS_ASSERT(a_done, clk, rst, scan_done |-> state == S_IDLE, "sort busy at scan end")
endmodule

FILE: src/hamming_radius_sketch_search.sv
// Hamming-radius sketch search: top level with config registers.
// Usage: items arrive on the in channel (in_valid/in_stall). An item with
// opcode 0 writes one database symbol; opcode 1 writes one query symbol and,
// with start_search set, launches a search. A search walks the entries one
// symbol at a time through a single compare unit, with early stop once the
// count exceeds max_errors; then the distance table is swept once per
// distance 0..max_errors (capped at 64). in_stall stays high for the whole
// search and until the last result is taken. Results leave on the out channel
// (out_valid/out_stall) from an output register; a stalled result holds.
// last_result marks the final result of a search, empty_res a search with no
// match. Configuration registers are written via cfg_valid/cfg_ready; the
// user must write them only while the block is idle, which the block itself
// does not enforce (index 0 symbol_bits, 1 vector_length, 2 max_errors,
// 3 entry_count). Reset (rst, synchronous) restores register defaults and
// idles both engines; stores are undefined until written.
module hamming_radius_sketch_search import hrss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [5:0] entry_index,
  input  logic [5:0] position,
  input  logic [7:0] symbol,
  input  logic       start_search,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] match_id,
  output logic [6:0] distance,
  output logic       last_result,
  output logic       empty_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  logic [3:0] symbol_bits;
  logic [6:0] vector_length, max_errors, entry_count;
  hrss_cfg_t cfg;
  logic acc, scan_busy, sort_busy, dv, sdone, pend;
  logic [EntW-1:0] de;
  logic [6:0] dval;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits <= 4'd8;
      vector_length <= 7'd64;
      max_errors <= 7'd10;
      entry_count <= 7'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYMBOL_BITS:   symbol_bits <= cfg_data[3:0];
        REG_VECTOR_LENGTH: vector_length <= cfg_data;
        REG_MAX_ERRORS:    max_errors <= cfg_data;
        REG_ENTRY_COUNT:   entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.mask  = sym_mask(symbol_bits);
  assign cfg.len   = (vector_length > 7'(MaxLength)) ? 7'(MaxLength) : vector_length;
  assign cfg.limit = max_errors;
  assign cfg.count = (entry_count > 7'(MaxEntries)) ? 7'(MaxEntries) : entry_count;

  // hold off input from search start until the sorter has finished
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else pend <= acc && opcode == OP_QUERY && start_search;
  end

  assign in_stall = scan_busy || sort_busy || pend || sdone;
  assign acc = in_valid && !in_stall;

  hrss_scan u_scan (
    .clk, .rst,
    .wr_en(acc), .wr_query(opcode == OP_QUERY), .wr_entry(entry_index),
    .wr_pos(position), .wr_sym(symbol), .start(pend), .cfg,
    .busy(scan_busy), .dist_valid(dv), .dist_entry(de), .dist_value(dval),
    .done(sdone)
  );

  hrss_order u_order (
    .clk, .rst, .dist_valid(dv), .dist_entry(de), .dist_value(dval),
    .scan_done(sdone), .cfg, .busy(sort_busy), .out_valid, .out_stall,
    .match_id, .distance, .last_result, .empty_res
  );

  `HRSS_ASSERT(a_no_acc_busy, clk, rst, scan_busy |-> in_stall, "accept during search")
  `HRSS_ASSERT(a_pend_start, clk, rst, pend |=> scan_busy, "search did not start")
  `HRSS_ASSERT_RST(a_rst_idle, clk, $past(rst) |-> !out_valid, "output after reset")
endmodule
